// ===== hdl/edsim_pkg.sv =====
// Shared constants, types and helpers for the edit distance similarity block.
package edsim_pkg;

  // Longest reference or candidate string kept
  localparam int MAX_LEN   = 64;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int REF_AW    = $clog2(MAX_LEN);
  localparam int ROW_DEPTH = MAX_LEN + 1;

  // Fixed field widths
  localparam int CHAR_W    = 8;
  localparam int CMD_W     = 2;
  localparam int DIST_W    = 7;
  localparam int THR_W     = 7;
  localparam int THR_RESET = 5;
  localparam int SAT_W     = (LEN_W > DIST_W) ? LEN_W : DIST_W;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [REF_AW-1:0] ref_addr_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [THR_W-1:0]  thr_t;

  // Command codes
  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_REF    = 2'd1;
  localparam cmd_t CMD_CAND   = 2'd2;
  localparam cmd_t CMD_FINISH = 2'd3;

  // Row store access for one cycle
  typedef struct packed {
    logic rd_en;
    len_t rd_addr;
    logic wr_en;
    len_t wr_addr;
    len_t wr_data;
    logic clear;
  } row_req_t;

  // Clamp a row value to the output width
  function automatic dist_t sat_dist(len_t d);
    logic [SAT_W-1:0] x;
    x = SAT_W'(d);
    if (x > SAT_W'((1 << DIST_W) - 1)) begin
      return DIST_W'((1 << DIST_W) - 1);
    end
    return x[DIST_W-1:0];
  endfunction

  // Distance strictly below threshold
  function automatic logic is_similar(len_t d, thr_t thr);
    return SAT_W'(d) < SAT_W'(thr);
  endfunction

endpackage

// ===== hdl/edsim_item_if.sv =====
// Input command channel: valid/ready with command and character payload.
interface edsim_item_if;
  logic               valid;
  logic               ready;
  edsim_pkg::cmd_t    command;
  edsim_pkg::char_t   char_code;

  modport source (output valid, command, char_code, input ready);
  modport sink   (input valid, command, char_code, output ready);
endinterface

// ===== hdl/edsim_result_if.sv =====
// Result channel: valid/ready with distance, similar and overflow payload.
interface edsim_result_if;
  logic             valid;
  logic             ready;
  edsim_pkg::dist_t distance;
  logic             similar;
  logic             overflow;

  modport source (output valid, distance, similar, overflow, input ready);
  modport sink   (input valid, distance, similar, overflow, output ready);
endinterface

// ===== hdl/edsim_cfg_if.sv =====
// Configuration write channel for the similarity threshold.
interface edsim_cfg_if;
  logic            valid;
  logic            ready;
  edsim_pkg::thr_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/edit_distance_similarity.sv =====
// Top level: Levenshtein distance sequencer over the reference and row memories.
// Clear and reference append leave the block idle; a candidate char walks the
//   reference row (one row cell per cycle), and needs no walk with an empty reference;
//   finish reads the last row cell, then waits in S_FIN while the result register is held.
// Throughput: one item at a time.
// Reset (rst, synchronous): lengths, overflow flag and row valid bits clear, threshold 5.
module edit_distance_similarity (
  input logic                  clk,
  input logic                  rst,
  edsim_item_if.sink           item,
  edsim_result_if.source       result,
  edsim_cfg_if.sink            cfg
);
  import edsim_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  len_t       ref_len;
  len_t       cand_len;
  logic       dropped;
  thr_t       thr;
  char_t      ch;
  len_t       rd_k;
  logic       rd_go;
  logic       p_vld;
  len_t       p_k;
  len_t       diag;
  len_t       left;
  logic       out_vld;
  dist_t      out_dist;
  logic       out_sim;
  logic       out_ovf;

  row_req_t   row_req;
  len_t       row_rdata;
  char_t      ref_rdata;
  logic       ref_wr_en;
  logic       walk_rd;
  logic       in_fire;
  logic       fin_load;
  len_t       cell_min;
  len_t       cell_v;
  len_t       fin_d;

  assign item.ready = (state == S_IDLE);
  assign in_fire    = item.valid && item.ready;
  assign walk_rd    = (state == S_WALK) && rd_go;
  assign fin_load   = (state == S_FIN) && (!out_vld || result.ready);
  assign ref_wr_en  = in_fire && (item.command == CMD_REF) &&
                      (cand_len == '0) && (ref_len < LEN_W'(MAX_LEN));

  // Memories
  edsim_ref_store u_ref_store (
    .clk     (clk),
    .wr_en   (ref_wr_en),
    .wr_addr (REF_AW'(ref_len)),
    .wr_data (item.char_code),
    .rd_en   (walk_rd),
    .rd_addr (REF_AW'(rd_k - LEN_W'(1))),
    .rd_data (ref_rdata)
  );

  edsim_row_store u_row_store (
    .clk     (clk),
    .rst     (rst),
    .req     (row_req),
    .rd_data (row_rdata)
  );

  // One DP cell: match takes diagonal, else min of three plus one
  always_comb begin
    cell_min = (diag < row_rdata) ? diag : row_rdata;
    cell_min = (cell_min < left) ? cell_min : left;
    cell_v   = (ref_rdata == ch) ? diag : cell_min + LEN_W'(1);
  end

  // Row store requests
  always_comb begin
    row_req = '0;
    if (walk_rd) begin
      row_req.rd_en   = 1'b1;
      row_req.rd_addr = rd_k;
    end else if (in_fire && (item.command == CMD_FINISH)) begin
      row_req.rd_en   = 1'b1;
      row_req.rd_addr = ref_len;
    end
    row_req.wr_en   = p_vld;
    row_req.wr_addr = p_k;
    row_req.wr_data = cell_v;
    row_req.clear   = (in_fire && (item.command == CMD_CLEAR)) || fin_load;
  end

  // Column zero is never read from memory; it equals the candidate length
  assign fin_d = (ref_len == '0) ? cand_len : row_rdata;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ref_len  <= '0;
      cand_len <= '0;
      dropped  <= 1'b0;
      rd_go    <= 1'b0;
      p_vld    <= 1'b0;
    end else begin
      p_vld <= walk_rd;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (item.command)
              CMD_CLEAR: begin
                ref_len  <= '0;
                cand_len <= '0;
                dropped  <= 1'b0;
              end
              CMD_REF: begin
                if (cand_len == '0) begin
                  if (ref_len < LEN_W'(MAX_LEN)) begin
                    ref_len <= ref_len + LEN_W'(1);
                  end else begin
                    dropped <= 1'b1;
                  end
                end
              end
              CMD_CAND: begin
                if (cand_len < LEN_W'(MAX_LEN)) begin
                  cand_len <= cand_len + LEN_W'(1);
                  if (ref_len != '0) begin
                    state <= S_WALK;
                    rd_go <= 1'b1;
                  end
                end else begin
                  dropped <= 1'b1;
                end
              end
              CMD_FINISH: begin
                state <= S_FIN;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (walk_rd && (rd_k == ref_len)) begin
            rd_go <= 1'b0;
          end
          if (p_vld && (p_k == ref_len)) begin
            state <= S_IDLE;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            cand_len <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Walk datapath: read address, pipeline stage, diagonal and left values
  always_ff @(posedge clk) begin
    p_k <= rd_k;
    if (in_fire && (item.command == CMD_CAND)) begin
      ch   <= item.char_code;
      diag <= cand_len;
      left <= cand_len + LEN_W'(1);
      rd_k <= LEN_W'(1);
    end else begin
      if (walk_rd && (rd_k != ref_len)) begin
        rd_k <= rd_k + LEN_W'(1);
      end
      if (p_vld) begin
        diag <= row_rdata;
        left <= cell_v;
      end
    end
  end

  // Threshold register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= thr_t'(THR_RESET);
    end else if (cfg.valid) begin
      thr <= cfg.data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fin_load) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_dist <= sat_dist(fin_d);
      out_sim  <= is_similar(fin_d, thr);
      out_ovf  <= dropped;
    end
  end

  assign result.valid    = out_vld;
  assign result.distance = out_dist;
  assign result.similar  = out_sim;
  assign result.overflow = out_ovf;

endmodule

// ===== hdl/edsim_ref_store.sv =====
// Reference character memory: one write port, one registered read port.
module edsim_ref_store (
  input  logic                clk,
  input  logic                wr_en,
  input  edsim_pkg::ref_addr_t wr_addr,
  input  edsim_pkg::char_t    wr_data,
  input  logic                rd_en,
  input  edsim_pkg::ref_addr_t rd_addr,
  output edsim_pkg::char_t    rd_data
);
  import edsim_pkg::*;

  char_t mem [MAX_LEN];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/edsim_row_store.sv =====
// DP row memory with per-entry valid bits; an unwritten entry k reads as k.
module edsim_row_store (
  input  logic                clk,
  input  logic                rst,
  input  edsim_pkg::row_req_t req,
  output edsim_pkg::len_t     rd_data
);
  import edsim_pkg::*;

  len_t                 mem [ROW_DEPTH];
  logic [ROW_DEPTH-1:0] vld;
  len_t                 rd_q;
  len_t                 rd_addr_q;
  logic                 rd_vld_q;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q      <= mem[req.rd_addr];
      rd_addr_q <= req.rd_addr;
      rd_vld_q  <= vld[req.rd_addr];
    end
  end

  // Valid bits: clear restores the initial row at once
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_q ? rd_q : rd_addr_q;

endmodule

// ===== hdl/edsim_checker.sv =====
// Port-level checks for the edit distance block, bound to the top level.
module edsim_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input edsim_pkg::cmd_t  item_command,
  input logic             result_valid,
  input logic             result_ready,
  input edsim_pkg::dist_t result_distance,
  input logic             result_similar,
  input logic             result_overflow
);
  import edsim_pkg::*;

  // A finish always needs a row read before it can report
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_command == CMD_FINISH) |=> !item_ready)
    else $error("ready stayed high after finish transaction");

  // Ready stays high after a clear or reference append
  a_short_cmds: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready &&
     (item_command == CMD_CLEAR || item_command == CMD_REF)) |=> item_ready)
    else $error("ready dropped after clear or reference transaction");

  // Distance never exceeds the longest string
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (SAT_W'(result_distance) <= SAT_W'(MAX_LEN)))
    else $error("distance out of range");

  // No result directly after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid &&
       $stable({result_distance, result_similar, result_overflow})))
    else $error("stalled result changed");

endmodule

bind edit_distance_similarity edsim_checker u_edsim_checker (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item.valid),
  .item_ready      (item.ready),
  .item_command    (item.command),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .result_distance (result.distance),
  .result_similar  (result.similar),
  .result_overflow (result.overflow)
);
